// ===== sv/tayl_pkg.sv =====
`timescale 1ns / 1ps
package tayl_pkg;

    localparam int SAMPLES_PER_WINDOW = 10;
    localparam int ANGLE_ITERATIONS   = 16;
    localparam int ITERS_USED  = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
    localparam int CNT_W       = $clog2(SAMPLES_PER_WINDOW + 1);
    localparam int SUM_W       = 22;
    localparam int NUM_W       = SUM_W + 1;
    localparam int SQ_W        = 2 * SUM_W;
    localparam int ROOT_W      = SUM_W;
    localparam int XY_W        = 36;
    localparam int Z_W         = 25;
    localparam int STEP_W      = 5;
    localparam int RIGHT_ANGLE = 23040;

    localparam logic [3:0] DIV_8 = 4'd8;
    localparam logic [3:0] DIV_4 = 4'd4;
    localparam logic [3:0] DIV_2 = 4'd2;
    localparam logic [3:0] DIV_1 = 4'd1;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_THR_LOW   = 2'd1,
        REG_THR_MID   = 2'd2,
        REG_THR_HIGH  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
        logic signed [19:0]      rate;
    } job_t;

    typedef struct packed {
        logic [15:0]        time_step;
        logic signed [31:0] thr_low;
        logic signed [31:0] thr_mid;
        logic signed [31:0] thr_high;
    } cfg_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] r;
        case (i)
            5'd0:  r = 25'sd2949120;
            5'd1:  r = 25'sd1740967;
            5'd2:  r = 25'sd919879;
            5'd3:  r = 25'sd466945;
            5'd4:  r = 25'sd234379;
            5'd5:  r = 25'sd117304;
            5'd6:  r = 25'sd58666;
            5'd7:  r = 25'sd29335;
            5'd8:  r = 25'sd14668;
            5'd9:  r = 25'sd7334;
            5'd10: r = 25'sd3667;
            5'd11: r = 25'sd1833;
            5'd12: r = 25'sd917;
            5'd13: r = 25'sd458;
            5'd14: r = 25'sd229;
            5'd15: r = 25'sd115;
            5'd16: r = 25'sd57;
            5'd17: r = 25'sd29;
            5'd18: r = 25'sd14;
            5'd19: r = 25'sd7;
            5'd20: r = 25'sd4;
            5'd21: r = 25'sd2;
            5'd22: r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/tilt_angle_yaw_level_classifier_unit.sv =====
`timescale 1ns / 1ps
// Tilt, yaw and level classifier. Accelerometer samples are summed in the front end, one
// transfer per cycle while the queue is not full, and every tenth sample closes a window
// that yields one result. Closed windows wait in a two-entry queue for the back end, which
// handles one window at a time: it takes the window from the queue, squares the x, y and z
// sums in turn, makes two angle passes on one shared angle unit, each of a start state,
// 22 square-root steps, 16 CORDIC rotations and a done state, then works out yaw and class
// and waits in its output state until the result is loaded. Samples keep flowing until two
// windows are queued behind the one in progress.
module tilt_angle_yaw_level_classifier_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [19:0] s_rate_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_roll_angle,
    output logic signed [15:0] m_pitch_angle,
    output logic signed [31:0] m_yaw_angle,
    output logic [3:0]         m_note_divisor
);
    import tayl_pkg::*;

    cfg_t cfg_reg;
    job_t push_data, pop_data;
    logic q_push, q_pop, q_full, q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.time_step <= 16'd6554;
            cfg_reg.thr_low   <= 32'sd0;
            cfg_reg.thr_mid   <= 32'sd512;
            cfg_reg.thr_high  <= 32'sd1024;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_TIME_STEP: cfg_reg.time_step <= cfg_wr_data[15:0];
                REG_THR_LOW:   cfg_reg.thr_low   <= cfg_wr_data;
                REG_THR_MID:   cfg_reg.thr_mid   <= cfg_wr_data;
                REG_THR_HIGH:  cfg_reg.thr_high  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    tayl_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_accel_x (s_accel_x),
        .s_accel_y (s_accel_y),
        .s_accel_z (s_accel_z),
        .s_rate_z  (s_rate_z),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    tayl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    tayl_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_empty        (q_empty),
        .q_data         (pop_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_roll_angle   (m_roll_angle),
        .m_pitch_angle  (m_pitch_angle),
        .m_yaw_angle    (m_yaw_angle),
        .m_note_divisor (m_note_divisor)
    );
endmodule

// ===== sv/tayl_front.sv =====
`timescale 1ns / 1ps
module tayl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_accel_x,
    input  logic signed [15:0]  s_accel_y,
    input  logic signed [15:0]  s_accel_z,
    input  logic signed [19:0]  s_rate_z,
    input  logic                q_full,
    output logic                q_push,
    output tayl_pkg::job_t      q_data
);
    import tayl_pkg::*;

    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
    logic                    take, last;

    assign s_ready    = !q_full;
    assign take       = s_valid && !q_full;
    assign last       = (cnt_reg == CNT_W'(SAMPLES_PER_WINDOW - 1));
    assign sum_x_next = sum_x_reg + SUM_W'(s_accel_x);
    assign sum_y_next = sum_y_reg + SUM_W'(s_accel_y);
    assign sum_z_next = sum_z_reg + SUM_W'(s_accel_z);
    assign q_push     = take && last;

    always_comb begin
        q_data.sx   = sum_x_next;
        q_data.sy   = sum_y_next;
        q_data.sz   = sum_z_next;
        q_data.rate = s_rate_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
        end else if (take) begin
            if (last) begin
                cnt_reg   <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
                sum_z_reg <= '0;
            end else begin
                cnt_reg   <= cnt_reg + 1'b1;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
            end
        end
    end
endmodule

// ===== sv/tayl_queue.sv =====
`timescale 1ns / 1ps
module tayl_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tayl_pkg::job_t push_data,
    input  logic           pop,
    output tayl_pkg::job_t pop_data,
    output logic           full,
    output logic           empty
);
    import tayl_pkg::*;

    job_t       mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)      count_reg <= count_reg + 2'd1;
            else if (pop && !push) count_reg <= count_reg - 2'd1;
        end
    end
endmodule

// ===== sv/tayl_angle.sv =====
`timescale 1ns / 1ps
module tayl_angle (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [tayl_pkg::NUM_W-1:0] num,
    input  logic [tayl_pkg::SQ_W-1:0]       sq,
    output logic                            done,
    output logic signed [15:0]              angle
);
    import tayl_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_SQRT = 4'b0010,
        A_CORD = 4'b0100,
        A_DONE = 4'b1000
    } astate_t;

    astate_t                  state_reg;
    logic [SQ_W-1:0]          v_reg;
    logic [ROOT_W+1:0]        rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [STEP_W-1:0]        step_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg, x_sh, y_sh;
    logic signed [Z_W-1:0]    z_reg, z_rnd;
    logic [ROOT_W+3:0]        rem_t, trial;
    logic                     fits;
    logic [ROOT_W-1:0]        root_next;

    assign rem_t     = {rem_reg, v_reg[SQ_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_t >= trial);
    assign root_next = {root_reg[ROOT_W-2:0], fits};
    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign z_rnd     = (z_reg + Z_W'(128)) >>> 8;
    assign done      = (state_reg == A_DONE);

    always_comb begin
        if (num_reg == '0) begin
            angle = '0;
        end else if (root_reg == '0) begin
            angle = num_reg[NUM_W-1] ? -16'sd23040 : 16'sd23040;
        end else if (z_rnd > Z_W'(RIGHT_ANGLE)) begin
            angle = 16'sd23040;
        end else if (z_rnd < -Z_W'(RIGHT_ANGLE)) begin
            angle = -16'sd23040;
        end else begin
            angle = z_rnd[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            unique case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        v_reg     <= sq;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        num_reg   <= num;
                        state_reg <= A_SQRT;
                    end
                end
                A_SQRT: begin
                    rem_reg  <= fits ? (ROOT_W+2)'(rem_t - trial) : rem_t[ROOT_W+1:0];
                    root_reg <= root_next;
                    v_reg    <= v_reg << 2;
                    if (step_reg == STEP_W'(ROOT_W - 1)) begin
                        step_reg  <= '0;
                        x_reg     <= XY_W'({root_next, 8'b0});
                        y_reg     <= XY_W'(num_reg) <<< 8;
                        z_reg     <= '0;
                        state_reg <= A_CORD;
                    end else begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                A_CORD: begin
                    if (!y_reg[XY_W-1]) begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_entry(step_reg);
                    end else begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_entry(step_reg);
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(ITERS_USED - 1)) state_reg <= A_DONE;
                end
                A_DONE: state_reg <= A_IDLE;
                default: state_reg <= A_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/tayl_back.sv =====
`timescale 1ns / 1ps
module tayl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tayl_pkg::cfg_t      cfg,
    input  logic                q_empty,
    input  tayl_pkg::job_t      q_data,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_roll_angle,
    output logic signed [15:0]  m_pitch_angle,
    output logic signed [31:0]  m_yaw_angle,
    output logic [3:0]          m_note_divisor
);
    import tayl_pkg::*;

    typedef enum logic [10:0] {
        B_IDLE    = 11'b00000000001,
        B_SQX     = 11'b00000000010,
        B_SQY     = 11'b00000000100,
        B_SQZ     = 11'b00000001000,
        B_ROLL    = 11'b00000010000,
        B_ROLL_W  = 11'b00000100000,
        B_PITCH   = 11'b00001000000,
        B_PITCH_W = 11'b00010000000,
        B_YAW_MUL = 11'b00100000000,
        B_YAW_ADD = 11'b01000000000,
        B_OUT     = 11'b10000000000
    } bstate_t;

    bstate_t                 state_reg;
    job_t                    job_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg;
    logic signed [SUM_W-1:0] mul_a;
    logic signed [SQ_W-1:0]  mul_p;
    logic signed [15:0]      roll_reg, pitch_reg, angle;
    logic signed [31:0]      yaw_reg;
    logic signed [36:0]      prod_reg, inc;
    logic signed [32:0]      yaw_sum;
    logic signed [33:0]      total;
    logic                    a_start, a_done, load;
    logic signed [NUM_W-1:0] a_num;
    logic [SQ_W-1:0]         a_sq;
    logic [3:0]              divisor;
    logic                    m_valid_reg;

    tayl_angle u_angle (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (a_start),
        .num     (a_num),
        .sq      (a_sq),
        .done    (a_done),
        .angle   (angle)
    );

    always_comb begin
        unique case (state_reg)
            B_SQY:   mul_a = job_reg.sy;
            B_SQZ:   mul_a = job_reg.sz;
            default: mul_a = job_reg.sx;
        endcase
    end
    assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_a);

    assign a_start = (state_reg == B_ROLL) || (state_reg == B_PITCH);
    assign a_num   = (state_reg == B_ROLL) ? NUM_W'(job_reg.sy) : -NUM_W'(job_reg.sx);
    assign a_sq    = (state_reg == B_ROLL) ? sqx_reg + sqz_reg : sqy_reg + sqz_reg;
    assign q_pop   = (state_reg == B_IDLE) && !q_empty;

    assign inc     = (prod_reg + 37'sd32768) >>> 16;
    assign yaw_sum = 33'(yaw_reg) + 33'(inc);
    assign total   = 34'(roll_reg) + 34'(pitch_reg) + 34'(yaw_reg);

    always_comb begin
        if (total <= 34'(cfg.thr_low))       divisor = DIV_8;
        else if (total <= 34'(cfg.thr_mid))  divisor = DIV_4;
        else if (total <= 34'(cfg.thr_high)) divisor = DIV_2;
        else                                 divisor = DIV_1;
    end

    assign load    = (state_reg == B_OUT) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            m_roll_angle   <= roll_reg;
            m_pitch_angle  <= pitch_reg;
            m_yaw_angle    <= yaw_reg;
            m_note_divisor <= divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            yaw_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load)                 m_valid_reg <= 1'b1;
            else if (m_ready)         m_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        job_reg   <= q_data;
                        state_reg <= B_SQX;
                    end
                end
                B_SQX: begin
                    sqx_reg   <= SQ_W'(mul_p);
                    state_reg <= B_SQY;
                end
                B_SQY: begin
                    sqy_reg   <= SQ_W'(mul_p);
                    state_reg <= B_SQZ;
                end
                B_SQZ: begin
                    sqz_reg   <= SQ_W'(mul_p);
                    state_reg <= B_ROLL;
                end
                B_ROLL:  state_reg <= B_ROLL_W;
                B_ROLL_W: begin
                    if (a_done) begin
                        roll_reg  <= angle;
                        state_reg <= B_PITCH;
                    end
                end
                B_PITCH: state_reg <= B_PITCH_W;
                B_PITCH_W: begin
                    if (a_done) begin
                        pitch_reg <= angle;
                        state_reg <= B_YAW_MUL;
                    end
                end
                B_YAW_MUL: begin
                    prod_reg  <= 37'(job_reg.rate) * 37'(signed'({1'b0, cfg.time_step}));
                    state_reg <= B_YAW_ADD;
                end
                B_YAW_ADD: begin
                    if (yaw_sum > 33'sh0_7FFF_FFFF)       yaw_reg <= 32'sh7FFF_FFFF;
                    else if (yaw_sum < -33'sh0_8000_0000) yaw_reg <= 32'sh8000_0000;
                    else                                  yaw_reg <= yaw_sum[31:0];
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (load) state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/tayl_checker.sv =====
`timescale 1ns / 1ps
module tayl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_roll_angle,
    input logic signed [15:0] m_pitch_angle,
    input logic [3:0]         m_note_divisor
);
    import tayl_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result dropped before transfer.");

    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_note_divisor == DIV_8 || m_note_divisor == DIV_4 ||
                     m_note_divisor == DIV_2 || m_note_divisor == DIV_1))
        else $error("Illegal note divisor.");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_angle <= 16'sd23040 && m_roll_angle >= -16'sd23040 &&
                     m_pitch_angle <= 16'sd23040 && m_pitch_angle >= -16'sd23040))
        else $error("Angle out of range.");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");
endmodule

bind tilt_angle_yaw_level_classifier_unit tayl_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_roll_angle   (m_roll_angle),
    .m_pitch_angle  (m_pitch_angle),
    .m_note_divisor (m_note_divisor)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import tayl_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 400;
    localparam int  WINDOWS_PER_PHASE = 10;
    localparam int  PHASE_COUNT = 8;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [31:0] yaw;
        logic [3:0]         divisor;
    } tilt_result_t;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [19:0] rz;
        bit                 typed;
        tilt_result_t       res;
    } sample_row_t;

    localparam longint ATAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_wr_index = '0;
    logic [31:0]        cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_accel_x = '0;
    logic signed [15:0] s_accel_y = '0;
    logic signed [15:0] s_accel_z = '0;
    logic signed [19:0] s_rate_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_roll_angle;
    logic signed [15:0] m_pitch_angle;
    logic signed [31:0] m_yaw_angle;
    logic [3:0]         m_note_divisor;

    tilt_result_t tilt_pending [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           no_gaps = 1'b0;

    longint acc_x, acc_y, acc_z, yaw_acc;
    int     samples_in;
    longint step_scale, thr_low, thr_mid, thr_high;

    sample_row_t directed [20];

    always #4 aclk = ~aclk;

    tilt_angle_yaw_level_classifier_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_rate_z(s_rate_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_roll_angle(m_roll_angle), .m_pitch_angle(m_pitch_angle),
        .m_yaw_angle(m_yaw_angle), .m_note_divisor(m_note_divisor)
    );

    function automatic longint floor_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint cordic_angle(longint num, longint den);
        longint x, y, z, nx;
        z = 0;
        if (num == 0) return 0;
        if (den == 0) return (num > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
        x = den * 256;
        y = num * 256;
        for (int i = 0; i < ITERS_USED; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_DEG[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_DEG[i];
            end
            x = nx;
        end
        z = (z + 128) >>> 8;
        if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
        if (z < -RIGHT_ANGLE) z = -RIGHT_ANGLE;
        return z;
    endfunction

    function automatic bit tilt_predict(sample_row_t row, output tilt_result_t r);
        longint roll, pitch, inc, total;
        acc_x += row.ax;
        acc_y += row.ay;
        acc_z += row.az;
        samples_in = (samples_in + 1) % 64;
        if (samples_in != 0 && samples_in < SAMPLES_PER_WINDOW) return 1'b0;
        roll = cordic_angle(acc_y, floor_root(acc_x * acc_x + acc_z * acc_z));
        pitch = cordic_angle(-acc_x, floor_root(acc_y * acc_y + acc_z * acc_z));
        inc = (longint'(row.rz) * step_scale + 32768) >>> 16;
        yaw_acc = yaw_acc + inc;
        if (yaw_acc > 64'sd2147483647) yaw_acc = 64'sd2147483647;
        if (yaw_acc < -64'sd2147483648) yaw_acc = -64'sd2147483648;
        total = roll + pitch + yaw_acc;
        r.roll = roll[15:0];
        r.pitch = pitch[15:0];
        r.yaw = yaw_acc[31:0];
        if (total <= thr_low) r.divisor = DIV_8;
        else if (total <= thr_mid) r.divisor = DIV_4;
        else if (total <= thr_high) r.divisor = DIV_2;
        else r.divisor = DIV_1;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        samples_in = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_TIME_STEP: step_scale = data[15:0];
            REG_THR_LOW:   thr_low = longint'($signed(data));
            REG_THR_MID:   thr_mid = longint'($signed(data));
            REG_THR_HIGH:  thr_high = longint'($signed(data));
        endcase
    endtask

    task automatic send_sample(sample_row_t row);
        int gap;
        tilt_result_t r;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_accel_x <= row.ax;
        s_accel_y <= row.ay;
        s_accel_z <= row.az;
        s_rate_z <= row.rz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tilt_predict(row, r)) tilt_pending.push_back(row.typed ? row.res : r);
    endtask

    function automatic logic signed [15:0] accel_value(int mode);
        int pick;
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 400)) - 200);
            default: begin
                pick = $urandom_range(0, 2);
                return (pick == 0) ? -16'sd32768 : (pick == 1) ? 16'sd32767 : 16'sd0;
            end
        endcase
    endfunction

    task automatic random_window();
        sample_row_t row;
        int mode;
        bit [2:0] zero_axes;
        mode = $urandom_range(0, 2);
        zero_axes = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'b000;
        row.typed = 1'b0;
        for (int k = 0; k < SAMPLES_PER_WINDOW; k++) begin
            row.ax = zero_axes[0] ? 16'sd0 : accel_value(mode);
            row.ay = zero_axes[1] ? 16'sd0 : accel_value(mode);
            row.az = zero_axes[2] ? 16'sd0 : accel_value(mode);
            if ($urandom_range(0, 4) == 0)
                row.rz = $urandom_range(0, 1) ? 20'sh7FFFF : -20'sh80000;
            else
                row.rz = 20'($urandom);
            send_sample(row);
        end
    endtask

    task automatic drain();
        while (tilt_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 100000)) - 50000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        forever begin
            int gap;
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (tilt_pending.size() == 0) begin
                $error("unexpected result transfer");
                fail_count++;
            end else begin
                tilt_result_t e;
                e = tilt_pending.pop_front();
                if (m_roll_angle !== e.roll) begin
                    $error("roll_angle expected %0d actual %0d", e.roll, m_roll_angle);
                    fail_count++;
                end
                if (m_pitch_angle !== e.pitch) begin
                    $error("pitch_angle expected %0d actual %0d", e.pitch, m_pitch_angle);
                    fail_count++;
                end
                if (m_yaw_angle !== e.yaw) begin
                    $error("yaw_angle expected %0d actual %0d", e.yaw, m_yaw_angle);
                    fail_count++;
                end
                if (m_note_divisor !== e.divisor) begin
                    $error("note_divisor expected %0d actual %0d", e.divisor, m_note_divisor);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        acc_x = 0; acc_y = 0; acc_z = 0; yaw_acc = 0; samples_in = 0;
        step_scale = 6554; thr_low = 0; thr_mid = 512; thr_high = 1024;

        for (int i = 0; i < 20; i++) begin
            directed[i].ax = 16'sd0;
            directed[i].ay = (i >= 10) ? 16'sd32767 : 16'sd0;
            directed[i].az = 16'sd0;
            directed[i].rz = (i % 2 == 0) ? 20'sh7FFFF : -20'sh80000;
            directed[i].typed = 1'b0;
        end
        directed[9].rz = -20'sh80000;
        directed[9].typed = 1'b1;
        directed[9].res = '{16'sd0, 16'sd0, -32'sd52432, DIV_8};
        directed[19].rz = 20'sh7FFFF;
        directed[19].typed = 1'b1;
        directed[19].res = '{16'sd23040, 16'sd0, 32'sd0, DIV_1};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_sample(directed[i]);
        s_valid <= 1'b0;
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: write_reg(REG_TIME_STEP, 32'd65535);
                1: write_reg(REG_TIME_STEP, 32'd0);
                default: write_reg(REG_TIME_STEP, $urandom_range(0, 65535));
            endcase
            if (p == 2) begin
                write_reg(REG_THR_LOW, 32'h7FFF_FFFF);
                write_reg(REG_THR_MID, 32'h8000_0000);
                write_reg(REG_THR_HIGH, 32'h8000_0000);
            end else if (p == 3) begin
                write_reg(REG_THR_LOW, 32'h8000_0000);
                write_reg(REG_THR_MID, 32'h8000_0000);
                write_reg(REG_THR_HIGH, 32'h7FFF_FFFF);
            end else begin
                write_reg(REG_THR_LOW, pick_threshold());
                write_reg(REG_THR_MID, pick_threshold());
                write_reg(REG_THR_HIGH, pick_threshold());
            end
            no_gaps = (p % 3 == 1);
            for (int w = 0; w < WINDOWS_PER_PHASE; w++) random_window();
            s_valid <= 1'b0;
            drain();
            no_gaps = 1'b0;
        end

        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/tayl_pkg.sv
sv/tayl_front.sv
sv/tayl_queue.sv
sv/tayl_angle.sv
sv/tayl_back.sv
sv/tilt_angle_yaw_level_classifier_unit.sv
sv/tayl_checker.sv
sim/tb_top.sv
